// ===== sv/nfc4_pkg.sv =====
// Shared types, constants and tables of the type 4 tag APDU responder.
`default_nettype none
package nfc4_pkg;

  localparam int unsigned NdefSizeDefault = 256;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [47:0] PasswordReset = 48'h534553414D45;
  localparam logic [55:0] AppIdReset    = 56'hD2760000850101;

  localparam logic [CfgIdxW-1:0] RegPassword = 8'd0;
  localparam logic [CfgIdxW-1:0] RegAppId    = 8'd1;

  localparam logic [8:0] PosMax = 9'd511;
  localparam logic [4:0] CcSize = 5'd15;

  localparam logic [7:0] InsSelect = 8'hA4;
  localparam logic [7:0] InsRead   = 8'hB0;
  localparam logic [7:0] InsUpdate = 8'hD6;
  localparam logic [7:0] P1ByName  = 8'h04;
  localparam logic [7:0] P1ByFid   = 8'h00;
  localparam logic [7:0] FidHigh   = 8'hE1;
  localparam logic [7:0] FidCc     = 8'h03;
  localparam logic [7:0] FidNdef   = 8'h04;

  localparam logic [15:0] SwOk       = 16'h9000;
  localparam logic [15:0] SwNotFound = 16'h6A82;
  localparam logic [15:0] SwNoSpace  = 16'h6A84;
  localparam logic [15:0] SwDenied   = 16'h6982;
  localparam logic [15:0] SwBadIns   = 16'h6D00;

  typedef enum logic [1:0] {
    FILE_NONE = 2'd0,
    FILE_CC   = 2'd1,
    FILE_NDEF = 2'd2
  } file_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_DECIDE,
    S_RD_REQ,
    S_RD_CAP,
    S_SW1,
    S_SW2,
    S_LAST
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PUSH_READ,
    PUSH_SW1,
    PUSH_SW2
  } push_sel_e;

  typedef struct packed {
    logic      absorb;
    logic      pad;
    logic      session;
    logic      decide;
    logic      rd_issue;
    logic      push;
    push_sel_e push_sel;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_busy;
    logic pad_needed;
    logic rd_pending;
    logic buf_full;
    logic out_free;
  } dp_status_t;

  // capability container, max file size field from the store size
  function automatic logic [7:0] cc_byte(logic [3:0] idx, logic [15:0] size_field);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h00;
      4'd1:    v = 8'h0F;
      4'd2:    v = 8'h20;
      4'd3:    v = 8'h00;
      4'd4:    v = 8'h54;
      4'd5:    v = 8'h00;
      4'd6:    v = 8'hFF;
      4'd7:    v = 8'h04;
      4'd8:    v = 8'h06;
      4'd9:    v = 8'hE1;
      4'd10:   v = 8'h04;
      4'd11:   v = size_field[15:8];
      4'd12:   v = size_field[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nfc4_if.sv =====
// Handshake channels of the responder: command bytes, response words, register writes.
`default_nettype none
interface nfc4_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] command_byte;
  logic       last_byte;
  modport source(output valid, opcode, command_byte, last_byte, input ready);
  modport sink(input valid, opcode, command_byte, last_byte, output ready);
endinterface

interface nfc4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] response_word;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        gate_open;
  modport source(output valid, response_word, byte_count, last_word, gate_open, input ready);
  modport sink(input valid, response_word, byte_count, last_word, gate_open, output ready);
endinterface

interface nfc4_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [63:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/nfc4_dpath.sv =====
// Datapath: header capture, flags, NDEF store, capability table, response packing.
`default_nettype none
module nfc4_dpath import nfc4_pkg::*; #(
  parameter int unsigned NDEF_SIZE = NdefSizeDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         in_byte_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        out_word_o,
  output logic [3:0]         out_count_o,
  output logic               out_last_o,
  output logic               out_gate_o
);

  localparam int unsigned AW = $clog2(NDEF_SIZE);
  localparam logic [16:0] SizeW = 17'(NDEF_SIZE);
  localparam logic [15:0] MaxField = 16'(NDEF_SIZE - 1);
  localparam logic [AW-1:0] LastAddr = AW'(NDEF_SIZE - 1);

  logic [47:0] pw_q;
  logic [55:0] aid_q;
  file_e       sel_q;
  logic        gate_q;
  logic [8:0]  pos_q;
  logic [31:0] hdr_q;
  logic [39:0] win_q;
  logic        aid_bad_q, wr_ok_q, fid_e1_q, fid_03_q, fid_04_q;
  logic [15:0] sw_q;
  logic [15:0] rd_addr_q;
  logic [7:0]  rd_rem_q;
  logic [63:0] buf_q;
  logic [3:0]  bcnt_q;
  logic        clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic [3:0]  out_count_q;
  logic        out_last_q;
  logic        out_gate_q;

  logic [7:0] mem [NDEF_SIZE];
  logic [7:0] mem_rd_q;
  logic [7:0] cc_rd_q;

  // absorb of one byte
  logic [7:0]  b;
  logic [31:0] hdr_ins;
  logic        wr_ok_new;
  logic        in_data;
  logic [8:0]  k;
  logic [55:0] aid_sh;
  logic        do_write;
  logic [47:0] win6;
  logic        pw_hit;
  logic [15:0] wa_full;

  always_comb begin
    b = cmd_i.pad ? 8'h00 : in_byte_i;
    hdr_ins = hdr_q;
    case (pos_q)
      9'd1:    hdr_ins[31:24] = hdr_q[31:24] | b;
      9'd2:    hdr_ins[23:16] = hdr_q[23:16] | b;
      9'd3:    hdr_ins[15:8]  = hdr_q[15:8] | b;
      9'd4:    hdr_ins[7:0]   = hdr_q[7:0] | b;
      default: hdr_ins = hdr_q;
    endcase
    wr_ok_new = (pos_q == 9'd4) && (hdr_ins[31:24] == InsUpdate) && (sel_q == FILE_NDEF)
                && (({1'b0, hdr_ins[23:8]} + {9'h000, hdr_ins[7:0]}) <= SizeW);
    in_data  = (pos_q >= 9'd5) && (pos_q < PosMax);
    k        = pos_q - 9'd5;
    aid_sh   = aid_q >> {3'd6 - k[2:0], 3'b000};
    do_write = in_data && wr_ok_q && (k < {1'b0, hdr_q[7:0]});
    win6     = {win_q, b};
    pw_hit   = (k >= 9'd5) && (win6 == pw_q);
    wa_full  = hdr_q[23:8] + {7'h00, k};
  end

  // response decision
  logic [7:0]  ins, p1, lc;
  logic [15:0] off;
  logic [16:0] size17;
  logic [16:0] rem17;
  file_e       sel_n;
  logic [15:0] sw_n;
  logic [7:0]  len_n;

  always_comb begin
    ins    = hdr_q[31:24];
    p1     = hdr_q[23:16];
    off    = hdr_q[23:8];
    lc     = hdr_q[7:0];
    size17 = (sel_q == FILE_CC) ? {12'h000, CcSize} : SizeW;
    rem17  = size17 - {1'b0, off};
    sel_n  = sel_q;
    sw_n   = SwOk;
    len_n  = 8'h00;
    priority if (ins == InsSelect) begin
      if (p1 == P1ByName) begin
        if (lc >= 8'd7 && !aid_bad_q) sel_n = FILE_NONE;
        else sw_n = SwNotFound;
      end else if (p1 == P1ByFid) begin
        if (fid_e1_q && fid_03_q) sel_n = FILE_CC;
        else if (fid_e1_q && fid_04_q) sel_n = FILE_NDEF;
        else sw_n = SwNotFound;
      end
    end else if (ins == InsRead) begin
      if ((sel_q == FILE_CC || sel_q == FILE_NDEF) && ({1'b0, off} < size17)) begin
        if (({1'b0, off} + {9'h000, lc}) > size17) len_n = rem17[7:0];
        else len_n = lc;
      end else begin
        sw_n = SwNotFound;
      end
    end else if (ins == InsUpdate) begin
      if (sel_q != FILE_NDEF) sw_n = SwDenied;
      else if (!wr_ok_q) sw_n = SwNoSpace;
    end else begin
      sw_n = SwBadIns;
    end
  end

  logic [7:0] rd_byte;
  logic [7:0] push_byte;

  always_comb begin
    rd_byte = (sel_q == FILE_CC) ? cc_rd_q : mem_rd_q;
    unique case (cmd_i.push_sel)
      PUSH_READ: push_byte = rd_byte;
      PUSH_SW1:  push_byte = sw_q[15:8];
      PUSH_SW2:  push_byte = sw_q[7:0];
      default:   push_byte = 8'h00;
    endcase
  end

  // store ports
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  always_comb begin
    mem_we = clr_busy_q || (cmd_i.absorb && do_write);
    mem_wa = clr_busy_q ? clr_addr_q : wa_full[AW-1:0];
    mem_wd = clr_busy_q ? 8'h00 : b;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.rd_issue) mem_rd_q <= mem[rd_addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) cc_rd_q <= cc_byte(rd_addr_q[3:0], MaxField);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q        <= PasswordReset;
      aid_q       <= AppIdReset;
      sel_q       <= FILE_NONE;
      gate_q      <= 1'b0;
      pos_q       <= '0;
      hdr_q       <= '0;
      win_q       <= '0;
      aid_bad_q   <= 1'b0;
      wr_ok_q     <= 1'b0;
      fid_e1_q    <= 1'b0;
      fid_03_q    <= 1'b0;
      fid_04_q    <= 1'b0;
      sw_q        <= SwOk;
      rd_addr_q   <= '0;
      rd_rem_q    <= '0;
      buf_q       <= '0;
      bcnt_q      <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
      out_gate_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegPassword) pw_q <= cfg_wdata_i[47:0];
        else if (cfg_index_i == RegAppId) aid_q <= cfg_wdata_i[55:0];
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == LastAddr) clr_busy_q <= 1'b0;
      end
      if (cmd_i.session || cmd_i.decide) begin
        pos_q     <= '0;
        hdr_q     <= '0;
        win_q     <= '0;
        aid_bad_q <= 1'b0;
        wr_ok_q   <= 1'b0;
        fid_e1_q  <= 1'b0;
        fid_03_q  <= 1'b0;
        fid_04_q  <= 1'b0;
      end else if (cmd_i.absorb) begin
        if (pos_q < PosMax) pos_q <= pos_q + 9'd1;
        hdr_q <= hdr_ins;
        if (wr_ok_new) wr_ok_q <= 1'b1;
        if (in_data) begin
          if (k < 9'd7 && b != aid_sh[7:0]) aid_bad_q <= 1'b1;
          if (k == 9'd0 && b == FidHigh) fid_e1_q <= 1'b1;
          if (k == 9'd1 && b == FidCc) fid_03_q <= 1'b1;
          if (k == 9'd1 && b == FidNdef) fid_04_q <= 1'b1;
          if (do_write) begin
            win_q <= win6[39:0];
            if (pw_hit) gate_q <= 1'b1;
          end
        end
      end
      if (cmd_i.session) begin
        sel_q  <= FILE_NONE;
        gate_q <= 1'b0;
      end
      if (cmd_i.decide) begin
        sel_q     <= sel_n;
        sw_q      <= sw_n;
        rd_addr_q <= off;
        rd_rem_q  <= len_n;
        buf_q     <= '0;
        bcnt_q    <= '0;
      end
      if (cmd_i.rd_issue) begin
        rd_addr_q <= rd_addr_q + 16'd1;
        rd_rem_q  <= rd_rem_q - 8'd1;
      end
      // a full buffer or the final bytes go to the output register
      if ((cmd_i.push && bcnt_q == 4'd8) || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
        out_word_q  <= buf_q;
        out_count_q <= cmd_i.emit_last ? bcnt_q : 4'd8;
        out_last_q  <= cmd_i.emit_last;
        out_gate_q  <= gate_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        if (bcnt_q == 4'd8) begin
          buf_q  <= {56'h0, push_byte};
          bcnt_q <= 4'd1;
        end else begin
          buf_q  <= buf_q | ({56'h0, push_byte} << {bcnt_q[2:0], 3'b000});
          bcnt_q <= bcnt_q + 4'd1;
        end
      end
    end
  end

  always_comb begin
    status_o.clr_busy   = clr_busy_q;
    status_o.pad_needed = (pos_q < 9'd12)
                          || ({1'b0, pos_q} < (10'd5 + {2'b00, hdr_q[7:0]}));
    status_o.rd_pending = (rd_rem_q != 8'h00);
    status_o.buf_full   = (bcnt_q == 4'd8);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;
  assign out_gate_o  = out_gate_q;

endmodule
`default_nettype wire

// ===== sv/nfc4_ctrl.sv =====
// Controller state machine: byte intake, zero padding, decision, read walk, word output.
`default_nettype none
module nfc4_ctrl import nfc4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.push_sel = PUSH_READ;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !status_i.clr_busy;
        if (in_valid_i && !status_i.clr_busy) begin
          if (in_opcode_i) begin
            cmd_o.session = 1'b1;
          end else begin
            cmd_o.absorb = 1'b1;
            if (in_last_i) state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (status_i.pad_needed) begin
          cmd_o.absorb = 1'b1;
          cmd_o.pad    = 1'b1;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_RD_REQ;
      end
      S_RD_REQ: begin
        if (status_i.rd_pending) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RD_CAP;
        end else begin
          state_d = S_SW1;
        end
      end
      S_RD_CAP: begin
        if (!status_i.buf_full || status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_RD_REQ;
        end
      end
      S_SW1: begin
        if (!status_i.buf_full || status_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = PUSH_SW1;
          state_d        = S_SW2;
        end
      end
      S_SW2: begin
        if (!status_i.buf_full || status_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = PUSH_SW2;
          state_d        = S_LAST;
        end
      end
      S_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/nfc_type4_tag_apdu_responder.sv =====
// Type 4 tag APDU responder: command bytes in, packed response words out.
// Usage:
//  in_i  : one APDU byte per word (opcode 0), last_byte on the final byte;
//          opcode 1 starts a session, clearing file choice and gate flag.
//  out_o : response words of up to eight bytes, read data then status word;
//          last_word marks the final word, the one that ends with the status word.
//  cfg_i : register writes (0 password, 1 application id), always ready.
// Timing: command bytes are taken while idle and the store is not being
// cleared. After the last byte the block pads missing bytes with zeros, one
// per cycle, up to max(12, 5+Lc) bytes, decides, then reads each data byte
// through the registered store/table read port, pushes the two status bytes
// and sends the last word.
// Reset: the NDEF store is swept to zero, one byte per cycle, over all NDEF_SIZE
// bytes; no command byte is taken meanwhile, register writes are.
// Stall: a full output word holds the packer until out_o.ready; a new
// command is taken while the last word still waits.
`default_nettype none
module nfc_type4_tag_apdu_responder import nfc4_pkg::*; #(
  parameter int unsigned NDEF_SIZE = NdefSizeDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nfc4_in_if.sink           in_i,
  nfc4_out_if.source        out_o,
  nfc4_cfg_if.sink          cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  nfc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_last_i   (in_i.last_byte),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nfc4_dpath #(
    .NDEF_SIZE (NDEF_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_i.command_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_wdata_i (cfg_i.wdata),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.response_word),
    .out_count_o (out_o.byte_count),
    .out_last_o  (out_o.last_word),
    .out_gate_o  (out_o.gate_open)
  );

`ifndef SYNTHESIS
  a_no_intake_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clr_busy |-> !in_i.ready)
    else $error("command byte taken during store clear");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_count != 4'd0) && (out_o.byte_count <= 4'd8))
    else $error("response word byte count out of range");

  a_mid_word_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_word) |-> (out_o.byte_count == 4'd8))
    else $error("non-final response word not full");
`endif

endmodule
`default_nettype wire
